[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic       CMD_PUT      = 1'b0;
    localparam logic       CMD_READ     = 1'b1;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    // APB byte address of the text_color register.
    localparam logic [2:0] ADDR_TEXT_COLOR = 3'd0;

    // One input word.
    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } tcw_in_t;

    // One result word.
    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic        scrolled;
    } tcw_out_t;

    // Classified operation handed from front to back.
    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_READ_NONE
    } tcw_op_kind_t;

    typedef struct packed {
        tcw_op_kind_t kind;
        logic [7:0]   char_code;
        logic [4:0]   read_row;
        logic [6:0]   read_col;
    } tcw_op_t;

    // Front/back handshake and status.
    typedef struct packed {
        logic init_busy;
        logic take;
    } tcw_link_t;

endpackage

[rtl/tcw_front.sv]
// Front end: accepts input words, classifies them, queues up to two operations.
`timescale 1ns / 1ps

module tcw_front #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tcw_pkg::tcw_in_t item,
    output tcw_pkg::tcw_op_t op,
    input  tcw_pkg::tcw_link_t link_in,
    output logic             op_valid
);
    import tcw_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    tcw_op_t    q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       in_ok;
    logic       take;
    logic       row_ok, col_ok;
    tcw_op_t    op_in;

    assign take     = link_in.take;
    assign full     = (cnt_reg == DEPTH) || link_in.init_busy;
    assign in_ok    = push && !full;
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];

    // classify
    always_comb
    begin
        row_ok          = {1'b0, item.read_row} < 6'(SCREEN_HEIGHT);
        col_ok          = {1'b0, item.read_col} < 8'(SCREEN_WIDTH);
        op_in.char_code = item.char_code;
        op_in.read_row  = item.read_row;
        op_in.read_col  = item.read_col;
        if (item.command == CMD_READ)
        begin
            op_in.kind = (row_ok && col_ok) ? OP_READ : OP_READ_NONE;
        end
        else if (item.char_code == NEWLINE_CODE)
        begin
            op_in.kind = OP_NEWLINE;
        end
        else
        begin
            op_in.kind = OP_PUT;
        end
    end

    always_comb
    begin
        wr_ptr_next = in_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take  ? ~rd_ptr_reg : rd_ptr_reg;
        case ({in_ok, take})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ok)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH)
        else $error("front queue count overflow");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> op_valid)
        else $error("back took from empty front queue");

    a_no_push_init: assert property (@(posedge clk) disable iff (!rst_n)
        link_in.init_busy |=> $stable(cnt_reg) || cnt_reg < $past(cnt_reg))
        else $error("word accepted during clearing pass");

endmodule

[rtl/tcw_back.sv]
// Back end: screen store, cursor, scroll and clearing sequencer, result register.
`timescale 1ns / 1ps

module tcw_back #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::tcw_op_t  op,
    input  logic              op_valid,
    output tcw_pkg::tcw_link_t link_out,
    input  logic [7:0]        text_color,
    input  logic              res_pop,
    output logic              res_valid,
    output tcw_pkg::tcw_out_t res
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int AW    = $clog2(CELLS);
    localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(SCREEN_HEIGHT - 1);
    localparam logic [RW:0]   ROW_COUNT = (RW + 1)'(SCREEN_HEIGHT);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR
    } state_t;

    state_t          state_reg, state_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [RW-1:0]   clr_row_reg, clr_row_next;
    logic [CW-1:0]   clr_col_reg, clr_col_next;
    logic [AW-1:0]   init_cnt_reg, init_cnt_next;
    logic            res_valid_reg, res_valid_next;
    tcw_out_t        res_reg, res_next;

    logic [15:0]     mem [CELLS];
    logic [15:0]     rd_data_reg;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [15:0]     wdata;

    logic            take, res_free, load_res, nl, scroll_sel;
    logic [15:0]     cell_sel;

    // logical row -> physical row of the circular row buffer
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] top);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= ROW_COUNT)
        begin
            s = s - ROW_COUNT;
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(SCREEN_WIDTH) + AW'(col);
    endfunction

    assign res_free           = !res_valid_reg || res_pop;
    assign res_valid          = res_valid_reg;
    assign res                = res_reg;
    assign link_out.init_busy = (state_reg == ST_INIT);
    assign link_out.take      = take;

    always_comb
    begin
        state_next    = state_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        top_next      = top_reg;
        clr_row_next  = clr_row_reg;
        clr_col_next  = clr_col_reg;
        init_cnt_next = init_cnt_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = '0;
        take          = 1'b0;
        load_res      = 1'b0;
        nl            = 1'b0;
        cell_sel      = '0;
        scroll_sel    = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                waddr = init_cnt_reg;
                wdata = {RESET_COLOR, BLANK_CODE};
                if (init_cnt_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (op_valid && res_free)
                begin
                    take = 1'b1;
                    unique case (op.kind)
                        OP_READ:
                        begin
                            raddr = cell_addr(phys_row(op.read_row[RW-1:0], top_reg),
                                              op.read_col[CW-1:0]);
                            state_next = ST_READ;
                        end
                        OP_READ_NONE:
                        begin
                            load_res = 1'b1;
                        end
                        OP_PUT:
                        begin
                            we    = 1'b1;
                            waddr = cell_addr(phys_row(cur_row_reg, top_reg), cur_col_reg);
                            wdata = {text_color, op.char_code};
                            if (cur_col_reg == COL_LAST)
                            begin
                                nl = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                                load_res     = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            nl = 1'b1;
                        end
                    endcase
                    if (nl)
                    begin
                        cur_col_next = '0;
                        if (cur_row_reg == ROW_LAST)
                        begin
                            // old top row becomes the new bottom row; blank it
                            top_next     = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                            clr_row_next = top_reg;
                            clr_col_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                            load_res     = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                cell_sel   = rd_data_reg;
                load_res   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cell_addr(clr_row_reg, clr_col_reg);
                wdata = {text_color, BLANK_CODE};
                if (clr_col_reg == COL_LAST)
                begin
                    scroll_sel = 1'b1;
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end
        endcase

        res_next.cell_value     = cell_sel;
        res_next.cursor_row_out = 5'(cur_row_next);
        res_next.cursor_col_out = 7'(cur_col_next);
        res_next.scrolled       = scroll_sel;
        res_valid_next          = load_res || (res_valid_reg && !res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            clr_row_reg   <= '0;
            clr_col_reg   <= '0;
            init_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            clr_row_reg   <= clr_row_next;
            clr_col_reg   <= clr_col_next;
            init_cnt_reg  <= init_cnt_next;
            res_valid_reg <= res_valid_next;
            if (load_res)
            begin
                res_reg <= res_next;
            end
        end
    end

    // screen store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg <= COL_LAST && cur_row_reg <= ROW_LAST && top_reg <= ROW_LAST)
        else $error("cursor or top row out of range");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_READ) |-> !take)
        else $error("operation taken while back end busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> res_free)
        else $error("result register overwritten");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (cur_row_reg == ROW_LAST && cur_col_reg == '0))
        else $error("cursor not at bottom line during scroll");

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer: config register and front/back wiring.
`timescale 1ns / 1ps
//
// Character-cell text console. Words enter through a queue-style port (push/full)
// and each one gives exactly one result word on a queue-style port (empty/pop).
// An input word either puts char_code at the cursor (newline 0x0A only moves
// the cursor and may scroll) or reads one cell by logical row and column.
//
// Structure: the front end classifies words into a two-entry queue; the back
// end owns the screen store (one write and one registered read per cycle), the
// cursor and a circular row offset, so a scroll only blanks one row.
//
// From accept to result a word is registered in the front queue, taken by the
// back end and registered in the result register; an in-range read also passes
// ST_READ, and a scroll first blanks the new bottom row in ST_CLEAR, one cell
// per cycle. Without scrolls the back end finishes one put or newline per cycle
// while pop keeps up; an in-range read holds it in ST_READ as well.
//
// Reset: cursor to 0,0, text_color to 0x07, then a clearing pass writes
// 0x0720 to all SCREEN_WIDTH * SCREEN_HEIGHT cells, one per cycle, with full
// held high; APB writes are taken as usual meanwhile.
// A stalled result (pop low) holds in the result register; the front queue
// still takes up to two more words before full rises.
//
module text_console_writer #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    // input word queue
    input  logic              push,
    output logic              full,
    input  tcw_pkg::tcw_in_t  item,
    // result word queue
    output logic              empty,
    input  logic              pop,
    output tcw_pkg::tcw_out_t result,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcw_pkg::*;

    logic [7:0] text_color_reg, text_color_next;
    logic       cfg_we;
    logic       cfg_hit;
    tcw_op_t    op;
    logic       op_valid;
    tcw_link_t  link;
    logic       res_valid;

    // --- config register ---
    // word index in paddr[2]
    assign cfg_hit = (paddr[2] == ADDR_TEXT_COLOR[2]);
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign text_color_next = cfg_we ? pwdata[7:0] : text_color_reg;
    assign prdata = cfg_hit ? {24'd0, text_color_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    // --- front: accept and classify ---
    tcw_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op       (op),
        .link_in  (link),
        .op_valid (op_valid)
    );

    // --- back: screen store and cursor ---
    tcw_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .op_valid   (op_valid),
        .link_out   (link),
        .text_color (text_color_reg),
        .res_pop    (pop && res_valid),
        .res_valid  (res_valid),
        .res        (result)
    );

    assign empty = !res_valid;

endmodule
